@@ design/siq_pkg.sv @@
// Shared types and constants for the sorted insert queue.
// Holds the entry layout, status codes, controller states and the
// command and status bundles between controller and datapath.
package siq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int KEY_W = 14;
	localparam int DAY_W = 5;
	localparam int MON_W = 4;
	localparam int TAG_W = 16;
	localparam int OCC_W = 5;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_POPPED   = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [DAY_W-1:0] day;
		logic [MON_W-1:0] month;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_INS_WALK,
		S_INS_HEAD,
		S_POP_HEAD,
		S_POP_WALK,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		RD_TAIL,
		RD_HEAD,
		RD_DEC,
		RD_INC
	} rd_mode_t;

	typedef enum logic [1:0] {
		WR_SHIFT_UP,
		WR_SHIFT_DN,
		WR_NEW_AT,
		WR_NEW_HEAD
	} wr_mode_t;

	typedef struct packed {
		logic     load_in;
		logic     rd_en;
		rd_mode_t rd_mode;
		logic     wr_en;
		wr_mode_t wr_mode;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     res_en;
		status_t  res_status;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic op_pop;
		logic cnt_zero;
		logic cnt_full;
		logic cnt_one;
		logic key_gt;
		logic idx_zero;
		logic idx_last;
		logic out_free;
	} stat_t;

endpackage

@@ design/siq_ctrl.sv @@
// Controller state machine for the sorted insert queue.
// Depends on siq_pkg; drives the datapath through cmd_t and reads stat_t.
module siq_ctrl import siq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output cmd_t  cmd,
	input  stat_t stat
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_nxt   = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!stat.op_pop) begin
					if (stat.cnt_full) begin
						cmd.res_en     = 1'b1;
						cmd.res_status = ST_FULL;
						state_nxt      = S_DONE;
					end else if (stat.cnt_zero) begin
						cmd.wr_en      = 1'b1;
						cmd.wr_mode    = WR_NEW_HEAD;
						cmd.cnt_inc    = 1'b1;
						cmd.res_en     = 1'b1;
						cmd.res_status = ST_INSERTED;
						state_nxt      = S_DONE;
					end else begin
						cmd.rd_en   = 1'b1;
						cmd.rd_mode = RD_TAIL;
						state_nxt   = S_INS_WALK;
					end
				end else begin
					if (stat.cnt_zero) begin
						cmd.res_en     = 1'b1;
						cmd.res_status = ST_EMPTY;
						state_nxt      = S_DONE;
					end else begin
						cmd.rd_en   = 1'b1;
						cmd.rd_mode = RD_HEAD;
						state_nxt   = S_POP_HEAD;
					end
				end
			end
			S_INS_WALK: begin
				cmd.wr_en = 1'b1;
				if (stat.key_gt) begin
					cmd.wr_mode = WR_SHIFT_UP;
					if (stat.idx_zero) begin
						state_nxt = S_INS_HEAD;
					end else begin
						cmd.rd_en   = 1'b1;
						cmd.rd_mode = RD_DEC;
					end
				end else begin
					cmd.wr_mode    = WR_NEW_AT;
					cmd.cnt_inc    = 1'b1;
					cmd.res_en     = 1'b1;
					cmd.res_status = ST_INSERTED;
					state_nxt      = S_DONE;
				end
			end
			S_INS_HEAD: begin
				cmd.wr_en      = 1'b1;
				cmd.wr_mode    = WR_NEW_HEAD;
				cmd.cnt_inc    = 1'b1;
				cmd.res_en     = 1'b1;
				cmd.res_status = ST_INSERTED;
				state_nxt      = S_DONE;
			end
			S_POP_HEAD: begin
				cmd.res_en     = 1'b1;
				cmd.res_status = ST_POPPED;
				if (stat.cnt_one) begin
					cmd.cnt_dec = 1'b1;
					state_nxt   = S_DONE;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_mode = RD_INC;
					state_nxt   = S_POP_WALK;
				end
			end
			S_POP_WALK: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_mode = WR_SHIFT_DN;
				if (stat.idx_last) begin
					cmd.cnt_dec = 1'b1;
					state_nxt   = S_DONE;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_mode = RD_INC;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

@@ design/siq_dpath.sv @@
// Datapath for the sorted insert queue: entry memory, count, walk index,
// result and output registers. Depends on siq_pkg; commanded by siq_ctrl.
module siq_dpath import siq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output stat_t            stat,
	input  logic             operation,
	input  logic [KEY_W-1:0] year_key,
	input  logic [DAY_W-1:0] day,
	input  logic [MON_W-1:0] month_number,
	input  logic [TAG_W-1:0] name_tag,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       status,
	output logic [KEY_W-1:0] out_year,
	output logic [DAY_W-1:0] out_day,
	output logic [MON_W-1:0] out_month,
	output logic [TAG_W-1:0] out_tag,
	output logic [OCC_W-1:0] occupancy
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	entry_t           mem_q [QUEUE_DEPTH];
	entry_t           rd_q;
	entry_t           new_q;
	entry_t           res_entry_q;
	entry_t           out_entry_q;
	entry_t           wr_data;
	status_t          res_status_q;
	status_t          out_status_q;
	logic             op_q;
	logic             out_valid_q;
	logic [CW-1:0]    count_q;
	logic [OCC_W-1:0] occ_q;
	logic [AW-1:0]    idx_q;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;

	always_comb begin
		unique case (cmd.rd_mode)
			RD_TAIL: rd_addr = AW'(count_q - 1'b1);
			RD_HEAD: rd_addr = '0;
			RD_DEC:  rd_addr = idx_q - 1'b1;
			RD_INC:  rd_addr = idx_q + 1'b1;
			default: rd_addr = '0;
		endcase
	end

	always_comb begin
		unique case (cmd.wr_mode)
			WR_SHIFT_UP: begin
				wr_addr = idx_q + 1'b1;
				wr_data = rd_q;
			end
			WR_SHIFT_DN: begin
				wr_addr = idx_q - 1'b1;
				wr_data = rd_q;
			end
			WR_NEW_AT: begin
				wr_addr = idx_q + 1'b1;
				wr_data = new_q;
			end
			WR_NEW_HEAD: begin
				wr_addr = '0;
				wr_data = new_q;
			end
			default: begin
				wr_addr = '0;
				wr_data = new_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q  <= mem_q[rd_addr];
			idx_q <= rd_addr;
		end
		if (cmd.load_in) begin
			op_q        <= operation;
			new_q.key   <= year_key;
			new_q.day   <= day;
			new_q.month <= month_number;
			new_q.tag   <= name_tag;
		end
		if (cmd.res_en) begin
			res_status_q <= cmd.res_status;
			res_entry_q  <= (cmd.res_status == ST_POPPED) ? rd_q : '0;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_entry_q  <= res_entry_q;
			occ_q        <= OCC_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.op_pop   = op_q;
		stat.cnt_zero = (count_q == '0);
		stat.cnt_full = (count_q == CW'(QUEUE_DEPTH));
		stat.cnt_one  = (count_q == CW'(1));
		stat.key_gt   = (rd_q.key > new_q.key);
		stat.idx_zero = (idx_q == '0);
		stat.idx_last = ((CW'(idx_q) + CW'(1)) == count_q);
		stat.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign out_year  = out_entry_q.key;
	assign out_day   = out_entry_q.day;
	assign out_month = out_entry_q.month;
	assign out_tag   = out_entry_q.tag;
	assign occupancy = occ_q;

endmodule

@@ design/sorted_insert_queue_by_key_top.sv @@
// Top level of the sorted insert queue: joins controller and datapath.
// Depends on siq_pkg, siq_ctrl and siq_dpath.
//
//  Channel  Handshake             Fields
//  input    in_valid / in_ready   operation, year_key, day, month_number, name_tag
//  output   out_valid / out_ready status, out_year, out_day, out_month, out_tag, occupancy
//
// An insert walks from the tail, moving up each entry with a greater key, and then
// writes the new entry; a pop reads the head and shifts the rest down by one place.
// The walk is set by the entry memory, which gives one read and one write per cycle.
// A new transaction is taken while the previous result still waits in the output register.
// Reset empties the queue; the entry memory itself is not cleared.
module sorted_insert_queue_by_key_top import siq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             operation,
	input  logic [KEY_W-1:0] year_key,
	input  logic [DAY_W-1:0] day,
	input  logic [MON_W-1:0] month_number,
	input  logic [TAG_W-1:0] name_tag,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       status,
	output logic [KEY_W-1:0] out_year,
	output logic [DAY_W-1:0] out_day,
	output logic [MON_W-1:0] out_month,
	output logic [TAG_W-1:0] out_tag,
	output logic [OCC_W-1:0] occupancy
);

	cmd_t  cmd;
	stat_t stat;

	siq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	siq_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.operation    (operation),
		.year_key     (year_key),
		.day          (day),
		.month_number (month_number),
		.name_tag     (name_tag),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.out_year     (out_year),
		.out_day      (out_day),
		.out_month    (out_month),
		.out_tag      (out_tag),
		.occupancy    (occupancy)
	);

endmodule

@@ design/siq_checker.sv @@
// Port-level checks for the sorted insert queue, bound to the top level.
// Depends on siq_pkg.
module siq_checker import siq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEPTH_DEF
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             operation,
	input logic [KEY_W-1:0] year_key,
	input logic [DAY_W-1:0] day,
	input logic [MON_W-1:0] month_number,
	input logic [TAG_W-1:0] name_tag,
	input logic             out_valid,
	input logic             out_ready,
	input logic [1:0]       status,
	input logic [KEY_W-1:0] out_year,
	input logic [DAY_W-1:0] out_day,
	input logic [MON_W-1:0] out_month,
	input logic [TAG_W-1:0] out_tag,
	input logic [OCC_W-1:0] occupancy
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_year)
			&& $stable(out_tag) && $stable(occupancy))
		else $error("Output transaction changed while stalled.");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_POPPED) |-> (out_year == '0) && (out_day == '0)
			&& (out_month == '0) && (out_tag == '0))
		else $error("Entry fields are not zero on a result without a popped entry.");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> occupancy == OCC_W'(QUEUE_DEPTH))
		else $error("Refused insert reported with the queue not full.");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY) |-> occupancy == '0)
		else $error("Empty pop reported with entries held.");

endmodule

bind sorted_insert_queue_by_key_top siq_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_siq_checker (.*);
